>>> rtl/mts_pkg.sv
package mts_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int COUNT_OUT_BITS = 7;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

endpackage

>>> rtl/mts_if.sv
interface mts_req_if import mts_pkg::*; ();
  logic                         valid;
  logic                         ready;
  req_t                         req_type;
  logic signed [FIELD_BITS-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface mts_rsp_if import mts_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] popped_value;
  logic signed [FIELD_BITS-1:0] top_value;
  logic signed [FIELD_BITS-1:0] min_value;
  logic [COUNT_OUT_BITS-1:0]    entry_count;
  logic                         is_empty;
  status_t                      status;

  modport source (output valid, popped_value, top_value, min_value, entry_count, is_empty,
                  status, input ready);
  modport sink   (input valid, popped_value, top_value, min_value, entry_count, is_empty,
                  status, output ready);
endinterface

>>> rtl/mts_ram.sv
module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> rtl/mts_min_unit.sv
module mts_min_unit #(
  parameter int WIDTH = 32
) (
  input  logic signed [WIDTH-1:0] cand,
  input  logic signed [WIDTH-1:0] below,
  input  logic                    below_valid,
  output logic signed [WIDTH-1:0] min_out
);

  // keep the running minimum on ties
  always_comb begin
    if (below_valid && !(cand < below)) begin
      min_out = below;
    end else begin
      min_out = cand;
    end
  end

endmodule

>>> rtl/min_tracking_stack_top.sv
// Channel   Direction  Fields
// in_req    sink       req_type, push_value
// out_rsp   source     popped_value, top_value, min_value, entry_count, is_empty, status
//
// A push runs the execute and done steps before the next request is accepted; a pop that
// leaves entries behind adds a read step: the new top comes back through the registered
// read port of the store. Overflow, underflow and an emptying pop skip the read step.
// rst_n clears the entry count and the sequencer; the store itself is not cleared.
// A result waits in the output register while out_rsp is stalled; the next item is taken
// meanwhile and held at its last step until the output register frees.
module min_tracking_stack_top import mts_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mts_req_if.sink   in_req,
  mts_rsp_if.source out_rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic signed [VALUE_BITS-1:0] top_val_r, top_val_nxt;
  logic signed [VALUE_BITS-1:0] top_min_r, top_min_nxt;
  req_t                         op_r, op_nxt;
  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic signed [VALUE_BITS-1:0] popped_r, popped_nxt;
  status_t                      status_r, status_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [FIELD_BITS-1:0] out_popped_r, out_popped_nxt;
  logic signed [FIELD_BITS-1:0] out_top_r, out_top_nxt;
  logic signed [FIELD_BITS-1:0] out_min_r, out_min_nxt;
  logic [COUNT_OUT_BITS-1:0]    out_count_r, out_count_nxt;
  logic                         out_empty_r, out_empty_nxt;
  status_t                      out_status_r, out_status_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [2*VALUE_BITS-1:0]      ram_wdata;
  logic [2*VALUE_BITS-1:0]      ram_rdata;
  logic [CW-1:0]                rd_idx;
  logic signed [VALUE_BITS-1:0] min_new;
  logic                         is_empty;

  mts_min_unit #(.WIDTH(VALUE_BITS)) u_min (
    .cand        (val_r),
    .below       (top_min_r),
    .below_valid (count_r != '0),
    .min_out     (min_new)
  );

  mts_ram #(.WIDTH(2 * VALUE_BITS), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign rd_idx    = count_r - CW'(2);
  assign ram_raddr = rd_idx[AW-1:0];
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = {min_new, val_r};
  assign is_empty  = (count_r == '0);

  assign in_req.ready          = (state_r == ST_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.popped_value  = out_popped_r;
  assign out_rsp.top_value     = out_top_r;
  assign out_rsp.min_value     = out_min_r;
  assign out_rsp.entry_count   = out_count_r;
  assign out_rsp.is_empty      = out_empty_r;
  assign out_rsp.status        = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    top_val_nxt    = top_val_r;
    top_min_nxt    = top_min_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    popped_nxt     = popped_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_popped_nxt = out_popped_r;
    out_top_nxt    = out_top_r;
    out_min_nxt    = out_min_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          op_nxt    = in_req.req_type;
          val_nxt   = VALUE_BITS'(in_req.push_value);
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        popped_nxt = '0;
        status_nxt = STATUS_OK;
        state_nxt  = ST_DONE;
        if (op_r == REQ_PUSH) begin
          if (count_r == CW'(DEPTH)) begin
            status_nxt = STATUS_OVERFLOW;
          end else begin
            ram_we      = 1'b1;
            top_val_nxt = val_r;
            top_min_nxt = min_new;
            count_nxt   = count_r + CW'(1);
          end
        end else begin
          if (is_empty) begin
            status_nxt = STATUS_UNDERFLOW;
          end else begin
            popped_nxt = top_val_r;
            count_nxt  = count_r - CW'(1);
            // refill the cached top from the store unless the pop empties it
            if (count_r != CW'(1)) begin
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        top_val_nxt = ram_rdata[VALUE_BITS-1:0];
        top_min_nxt = ram_rdata[2*VALUE_BITS-1:VALUE_BITS];
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register frees
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = FIELD_BITS'(popped_r);
          out_top_nxt    = is_empty ? '0 : FIELD_BITS'(top_val_r);
          out_min_nxt    = is_empty ? '0 : FIELD_BITS'(top_min_r);
          out_count_nxt  = COUNT_OUT_BITS'(count_r);
          out_empty_nxt  = is_empty;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_val_r    <= top_val_nxt;
    top_min_r    <= top_min_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    popped_r     <= popped_nxt;
    status_r     <= status_nxt;
    out_popped_r <= out_popped_nxt;
    out_top_r    <= out_top_nxt;
    out_min_r    <= out_min_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
